// ----- rtl/qebmidi_pkg.sv -----
// Shared types, constants and helper functions for the encoder bank to MIDI CC unit.
// Used by qebmidi_update and quadrature_encoder_bank_to_midi_cc_unit. No dependencies.
package qebmidi_pkg;

  localparam int ENCODERS_DEF = 8;
  localparam int ENC_W        = 3;
  localparam int ENC_CNT_W    = 4;
  localparam int VAL_W        = 7;
  localparam int CHAN_W       = 4;
  localparam int NEWVAL_W     = 8;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 56;

  localparam logic [NEWVAL_W-1:0] POS_MAX = 8'd127;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED_MASK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUES    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIDI_CHANNELS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROLLERS   = 3'd3;

  // Input item mode
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_LOAD   = 1'b1;

  // Phase transitions {previous AB, new AB}
  localparam logic [3:0] TR_UP_0 = 4'b1101;
  localparam logic [3:0] TR_UP_1 = 4'b0100;
  localparam logic [3:0] TR_UP_2 = 4'b0010;
  localparam logic [3:0] TR_UP_3 = 4'b1011;
  localparam logic [3:0] TR_DN_0 = 4'b1110;
  localparam logic [3:0] TR_DN_1 = 4'b0111;
  localparam logic [3:0] TR_DN_2 = 4'b0001;
  localparam logic [3:0] TR_DN_3 = 4'b1000;

  typedef struct packed {
    logic [VAL_W-1:0] pos;
    logic [1:0]       phase;
    logic             report;
  } upd_t;

  function automatic logic counts_up(input logic [3:0] trans);
    return trans inside {TR_UP_0, TR_UP_1, TR_UP_2, TR_UP_3};
  endfunction

  function automatic logic counts_down(input logic [3:0] trans);
    return trans inside {TR_DN_0, TR_DN_1, TR_DN_2, TR_DN_3};
  endfunction

endpackage

// ----- rtl/qebmidi_update.sv -----
// Next-value logic for one encoder: clamp, count on quadrature transitions, or load.
// Depends on qebmidi_pkg.
module qebmidi_update (
  input  logic                               mode,
  input  logic                               pin_a,
  input  logic                               pin_b,
  input  logic [qebmidi_pkg::NEWVAL_W-1:0]   new_value,
  input  logic [qebmidi_pkg::VAL_W-1:0]      pos_before,
  input  logic [1:0]                         last_phase,
  input  logic [qebmidi_pkg::VAL_W-1:0]      limit,
  output qebmidi_pkg::upd_t                  upd
);

  logic [qebmidi_pkg::VAL_W-1:0] clamped;
  logic [3:0]                    trans;

  always_comb begin
    clamped    = (pos_before > limit) ? limit : pos_before;
    trans      = {last_phase, pin_a, pin_b};
    upd.phase  = {pin_a, pin_b};
    upd.pos    = clamped;
    upd.report = 1'b0;
    if (mode == qebmidi_pkg::MODE_LOAD) begin
      upd.pos    = (new_value > qebmidi_pkg::POS_MAX) ? qebmidi_pkg::POS_MAX[6:0]
                                                      : new_value[6:0];
      upd.report = 1'b1;
    end else begin
      if (clamped < limit && qebmidi_pkg::counts_up(trans)) begin
        upd.pos = clamped + 7'd1;
      end else if (clamped != '0 && qebmidi_pkg::counts_down(trans)) begin
        upd.pos = clamped - 7'd1;
      end
      upd.report = (upd.pos != pos_before);
    end
  end

endmodule

// ----- rtl/quadrature_encoder_bank_to_midi_cc_unit.sv -----
// Encoder bank to MIDI control-change unit: top level with input register, per-encoder
// state, configuration registers and output register. Depends on qebmidi_pkg, qebmidi_update.
// Items pass through the input register and the output register. Throughput: one item per
// cycle unless a result held by m_tready low holds the input; the state read-modify-write
// sits between the input and output registers, so consecutive items to the same encoder see
// each other's updates. Reset clears valid flags, configuration and encoder state, not data.
module quadrature_encoder_bank_to_midi_cc_unit #(
  parameter int ENCODERS = qebmidi_pkg::ENCODERS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // encoder[2:0], pin_a[3], pin_b[4], new_value[12:5], zero[15:13]
  input  logic [15:0]                          s_tdata,
  // mode[0]
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // source_encoder[2:0], midi_channel[6:3], controller_number[13:7],
  // control_value[20:14], zero[23:21]
  output logic [23:0]                          m_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [qebmidi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qebmidi_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int ENC_W  = qebmidi_pkg::ENC_W;
  localparam int VAL_W  = qebmidi_pkg::VAL_W;
  localparam int CHAN_W = qebmidi_pkg::CHAN_W;

  // configuration
  logic [7:0]  enabled_mask;
  logic [55:0] max_values;
  logic [31:0] midi_channels;
  logic [55:0] controllers;

  // input register
  logic                               in_valid;
  logic                               in_mode;
  logic [ENC_W-1:0]                   in_enc;
  logic                               in_pin_a;
  logic                               in_pin_b;
  logic [qebmidi_pkg::NEWVAL_W-1:0]   in_new_value;

  // encoder state
  logic [VAL_W-1:0] position   [ENCODERS];
  logic [1:0]       last_phase [ENCODERS];

  // output register
  logic        out_valid;
  logic [23:0] out_data;

  logic              advance;
  logic              hit;
  logic              emit;
  logic [VAL_W-1:0]  pos_rd;
  logic [1:0]        phase_rd;
  logic [VAL_W-1:0]  maxv;
  logic [VAL_W-1:0]  ctrl;
  logic [CHAN_W-1:0] chan;
  qebmidi_pkg::upd_t upd;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled_mask  <= '0;
      max_values    <= '0;
      midi_channels <= '0;
      controllers   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        qebmidi_pkg::REG_ENABLED_MASK:  enabled_mask  <= cfg_data[7:0];
        qebmidi_pkg::REG_MAX_VALUES:    max_values    <= cfg_data[55:0];
        qebmidi_pkg::REG_MIDI_CHANNELS: midi_channels <= cfg_data[31:0];
        qebmidi_pkg::REG_CONTROLLERS:   controllers   <= cfg_data[55:0];
        default: ;
      endcase
    end
  end

  // capture an item whenever the stage is free or moving on
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_mode      <= s_tuser;
      in_enc       <= s_tdata[2:0];
      in_pin_a     <= s_tdata[3];
      in_pin_b     <= s_tdata[4];
      in_new_value <= s_tdata[12:5];
    end
  end

  always_comb begin
    pos_rd   = '0;
    phase_rd = '0;
    for (int e = 0; e < ENCODERS; e++) begin
      if (in_enc == ENC_W'(e)) begin
        pos_rd   = position[e];
        phase_rd = last_phase[e];
      end
    end
  end

  assign maxv = max_values[in_enc * 7 +: 7];
  assign ctrl = controllers[in_enc * 7 +: 7];
  assign chan = midi_channels[in_enc * 4 +: 4];
  assign hit  = (qebmidi_pkg::ENC_CNT_W'(in_enc) < qebmidi_pkg::ENC_CNT_W'(ENCODERS))
                && enabled_mask[in_enc];
  assign emit = hit && upd.report && (ctrl != '0);

  qebmidi_update u_update (
    .mode       (in_mode),
    .pin_a      (in_pin_a),
    .pin_b      (in_pin_b),
    .new_value  (in_new_value),
    .pos_before (pos_rd),
    .last_phase (phase_rd),
    .limit      (maxv),
    .upd        (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < ENCODERS; e++) begin
        position[e]   <= '0;
        last_phase[e] <= '0;
      end
    end else if (advance && hit) begin
      for (int e = 0; e < ENCODERS; e++) begin
        if (in_enc == ENC_W'(e)) begin
          position[e] <= upd.pos;
          // load mode leaves the phase alone
          if (in_mode == qebmidi_pkg::MODE_SAMPLE) begin
            last_phase[e] <= upd.phase;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_data <= {3'b000, upd.pos, ctrl, chan, in_enc};
    end
  end

  a_ctrl_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[13:7] != '0))
    else $error("result with zero controller number");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (!m_tvalid && !in_valid))
    else $error("item pending straight after reset");

  a_sample_within_max: assert property (@(posedge clk) disable iff (rst)
    (advance && emit && in_mode == qebmidi_pkg::MODE_SAMPLE) |=>
      (m_tdata[20:14] <= $past(maxv)))
    else $error("sampled value above encoder maximum");

  a_load_saturates: assert property (@(posedge clk) disable iff (rst)
    (advance && emit && in_mode == qebmidi_pkg::MODE_LOAD && in_new_value[7]) |=>
      (m_tdata[20:14] == qebmidi_pkg::POS_MAX[6:0]))
    else $error("loaded value not saturated");

endmodule

// ----- dv/tb_quadrature_encoder_bank_to_midi_cc_unit.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the encoder bank to MIDI CC unit: directed and random stream
// traffic against a cycle-free model of the bank held in a small scoreboard class.
// Depends on qebmidi_pkg and the quadrature_encoder_bank_to_midi_cc_unit RTL.
module tb_quadrature_encoder_bank_to_midi_cc_unit;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int FLUSH_CYCLES  = 4;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 192;
  localparam int IDX_W         = qebmidi_pkg::CFG_IDX_W;
  localparam int DATA_W        = qebmidi_pkg::CFG_DATA_W;
  localparam logic [IDX_W-1:0] REG_UNUSED_LO = qebmidi_pkg::REG_CONTROLLERS + 3'd1;
  // directed settings, encoder 7 in the top bits
  localparam bit [55:0] DIR_LIMITS = {7'd127, 7'd1, 7'd64, 7'd127, 7'd127, 7'd2, 7'd0, 7'd127};
  localparam bit [31:0] DIR_CHANS  = 32'hA3F1_95F0;
  localparam bit [55:0] DIR_CTRLS  = {7'd99, 7'd20, 7'd10, 7'd64, 7'd0, 7'd7, 7'd1, 7'd127};

  typedef struct packed {
    bit [2:0] src;
    bit [3:0] chan;
    bit [6:0] ctrl;
    bit [6:0] val;
  } cc_t;

  class cc_tracker;
    bit [7:0]  enabled;
    bit [55:0] limits;
    bit [31:0] channels;
    bit [55:0] ctrl_nums;
    bit [6:0]  position [8];
    bit [1:0]  last_ab [8];
    cc_t       pending_cc [$];
    int        errors;

    function bit is_advance(bit [3:0] tr);
      case (tr)
        qebmidi_pkg::TR_UP_0, qebmidi_pkg::TR_UP_1,
        qebmidi_pkg::TR_UP_2, qebmidi_pkg::TR_UP_3: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function bit is_retreat(bit [3:0] tr);
      case (tr)
        qebmidi_pkg::TR_DN_0, qebmidi_pkg::TR_DN_1,
        qebmidi_pkg::TR_DN_2, qebmidi_pkg::TR_DN_3: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function void apply_write(bit [IDX_W-1:0] idx, bit [DATA_W-1:0] data);
      case (idx)
        qebmidi_pkg::REG_ENABLED_MASK:  enabled   = data[7:0];
        qebmidi_pkg::REG_MAX_VALUES:    limits    = data;
        qebmidi_pkg::REG_MIDI_CHANNELS: channels  = data[31:0];
        qebmidi_pkg::REG_CONTROLLERS:   ctrl_nums = data;
        default: ;
      endcase
    endfunction

    function void note_item(bit mode, bit [2:0] k, bit a, bit b, bit [7:0] nv);
      bit [6:0] lim;
      bit [6:0] ctl;
      bit [6:0] pos;
      bit [6:0] prev;
      bit [3:0] chn;
      bit       rep;
      cc_t      e;
      if (!enabled[k]) return;
      lim = limits[7*k +: 7];
      ctl = ctrl_nums[7*k +: 7];
      chn = channels[4*k +: 4];
      if (mode == qebmidi_pkg::MODE_LOAD) begin
        pos = (nv > qebmidi_pkg::POS_MAX) ? qebmidi_pkg::POS_MAX[6:0] : nv[6:0];
        position[k] = pos;
        rep = 1'b1;
      end else begin
        prev = position[k];
        // clamp to the limit before counting
        pos = (prev > lim) ? lim : prev;
        if (pos < lim && is_advance({last_ab[k], a, b}))
          pos = pos + 7'd1;
        else if (pos != 7'd0 && is_retreat({last_ab[k], a, b}))
          pos = pos - 7'd1;
        position[k] = pos;
        last_ab[k] = {a, b};
        rep = (pos != prev);
      end
      if (rep && ctl != 7'd0) begin
        e.src = k;
        e.chan = chn;
        e.ctrl = ctl;
        e.val = pos;
        pending_cc.push_back(e);
      end
    endfunction

    function void check_cc(logic [23:0] d);
      cc_t e;
      if (pending_cc.size() == 0) begin
        $error("control change %h with none expected", d);
        errors++;
        return;
      end
      e = pending_cc.pop_front();
      if (d[2:0] !== e.src) begin
        $error("source_encoder expected %0d actual %0d", e.src, d[2:0]);
        errors++;
      end
      if (d[6:3] !== e.chan) begin
        $error("midi_channel expected %0d actual %0d", e.chan, d[6:3]);
        errors++;
      end
      if (d[13:7] !== e.ctrl) begin
        $error("controller_number expected %0d actual %0d", e.ctrl, d[13:7]);
        errors++;
      end
      if (d[20:14] !== e.val) begin
        $error("control_value expected %0d actual %0d", e.val, d[20:14]);
        errors++;
      end
      if (d[23:21] !== 3'b000) begin
        $error("m_tdata padding expected 0 actual %0d", d[23:21]);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [15:0]       s_tdata;
  logic              s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic [23:0]       m_tdata;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index;
  logic [DATA_W-1:0] cfg_data;

  cc_tracker cc_model = new;
  bit        quiet;
  bit [1:0]  stim_ab [8];
  int        cycle_count;

  quadrature_encoder_bank_to_midi_cc_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // note every handshake on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        cc_model.note_item(s_tuser, s_tdata[2:0], s_tdata[3], s_tdata[4], s_tdata[12:5]);
      if (cfg_valid && cfg_ready)
        cc_model.apply_write(cfg_index, cfg_data);
      if (m_tvalid && m_tready)
        cc_model.check_cc(m_tdata);
    end
  end

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 11);
  endfunction

  // receiver: stall a drawn number of cycles before each item
  initial begin
    int stall;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      @(negedge clk);
    end
  end

  task automatic send_item(bit mode, bit [2:0] k, bit a, bit b, bit [7:0] nv);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tuser = mode;
    s_tdata = {3'b000, nv, b, a, k};
    s_tvalid = 1'b1;
    do @(posedge clk); while (s_tready !== 1'b1);
    @(negedge clk);
  endtask

  // hold the sender until every pending message is out and the pipe is empty
  task automatic drain_bank();
    s_tvalid = 1'b0;
    while (cc_model.pending_cc.size() != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(bit [IDX_W-1:0] idx, bit [DATA_W-1:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic setup_phase(int ph);
    bit [7:0]  mask;
    bit [55:0] lims;
    bit [31:0] chans;
    bit [55:0] ctrls;
    bit [63:0] junk;
    mask = 8'hFF;
    junk = {$urandom, $urandom};
    for (int k = 0; k < 8; k++) begin
      chans[4*k +: 4] = 4'($urandom_range(0, 15));
      ctrls[7*k +: 7] = 7'($urandom_range(1, 127));
      lims[7*k +: 7] = 7'($urandom_range(0, 127));
      case (ph)
        1: begin
          lims[7*k +: 7] = 7'h7F;
          chans[4*k +: 4] = 4'hF;
        end
        2: begin
          lims[7*k +: 7] = 7'($urandom_range(0, 3));
          if ($urandom_range(0, 7) == 0) ctrls[7*k +: 7] = 7'd0;
        end
        3, 6: ctrls[7*k +: 7] = 7'($urandom_range(0, 127));
        4: begin
          chans[4*k +: 4] = 4'h0;
          ctrls[7*k +: 7] = 7'h7F;
        end
        5: lims[7*k +: 7] = $urandom_range(0, 1) ? 7'h7F : 7'h00;
        default: ;
      endcase
    end
    if (ph == 0) begin
      mask = 8'h7F;
      lims = DIR_LIMITS;
      chans = DIR_CHANS;
      ctrls = DIR_CTRLS;
    end else if (ph == 3 || ph == 6) begin
      mask = 8'($urandom_range(1, 255));
    end
    // writes past the register list must change nothing
    write_reg(IDX_W'($urandom_range(REG_UNUSED_LO, 7)), junk[55:0]);
    write_reg(qebmidi_pkg::REG_ENABLED_MASK, {junk[55:8], mask});
    write_reg(qebmidi_pkg::REG_MAX_VALUES, lims);
    write_reg(qebmidi_pkg::REG_MIDI_CHANNELS, {junk[55:32], chans});
    write_reg(qebmidi_pkg::REG_CONTROLLERS, ctrls);
    cfg_valid = 1'b0;
  endtask

  function automatic bit [1:0] next_gray(bit [1:0] ab, bit up);
    case (ab)
      2'b00: return up ? 2'b10 : 2'b01;
      2'b10: return up ? 2'b11 : 2'b00;
      2'b11: return up ? 2'b01 : 2'b10;
      default: return up ? 2'b00 : 2'b11;
    endcase
  endfunction

  // mostly clean rotations on one encoder at a time, with loads and pin noise mixed in
  task automatic run_phase(int n_items);
    int       live;
    int       r;
    bit [2:0] k;
    bit [2:0] cur_k;
    bit       cur_up;
    bit [1:0] ab;
    live = 0;
    cur_k = 3'($urandom_range(0, 7));
    cur_up = 1'($urandom_range(0, 1));
    while (live < n_items) begin
      if ($urandom_range(0, 63) == 0) quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 10) begin
        k = 3'($urandom_range(0, 7));
        send_item(qebmidi_pkg::MODE_LOAD, k, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else if (r < 16) begin
        k = 3'($urandom_range(0, 7));
        ab = 2'($urandom_range(0, 3));
        send_item(qebmidi_pkg::MODE_SAMPLE, k, ab[1], ab[0], 8'($urandom_range(0, 255)));
        stim_ab[k] = ab;
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          cur_k = 3'($urandom_range(0, 7));
          cur_up = 1'($urandom_range(0, 1));
        end
        k = cur_k;
        ab = next_gray(stim_ab[k], cur_up);
        send_item(qebmidi_pkg::MODE_SAMPLE, k, ab[1], ab[0], 8'($urandom_range(0, 255)));
        stim_ab[k] = ab;
      end
      live++;
      if ($urandom_range(0, 299) == 0) drain_bank();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = qebmidi_pkg::MODE_SAMPLE;
    cfg_valid = 1'b0;
    cfg_index = qebmidi_pkg::REG_ENABLED_MASK;
    cfg_data = '0;
    quiet = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // nothing is enabled straight after reset
    send_item(qebmidi_pkg::MODE_LOAD, 3'd0, 1'b0, 1'b0, 8'd5);
    drain_bank();
    setup_phase(0);
    send_item(qebmidi_pkg::MODE_LOAD, 3'd0, 1'b0, 1'b0, 8'd255);
    send_item(qebmidi_pkg::MODE_LOAD, 3'd0, 1'b0, 1'b0, 8'd0);
    send_item(qebmidi_pkg::MODE_LOAD, 3'd0, 1'b0, 1'b0, 8'd0);
    // four steps up, four steps down, then a step down at zero
    send_item(qebmidi_pkg::MODE_SAMPLE, 3'd0, 1'b1, 1'b0, 8'd0);
    send_item(qebmidi_pkg::MODE_SAMPLE, 3'd0, 1'b1, 1'b1, 8'd0);
    send_item(qebmidi_pkg::MODE_SAMPLE, 3'd0, 1'b0, 1'b1, 8'd0);
    send_item(qebmidi_pkg::MODE_SAMPLE, 3'd0, 1'b0, 1'b0, 8'd0);
    send_item(qebmidi_pkg::MODE_SAMPLE, 3'd0, 1'b0, 1'b1, 8'd0);
    send_item(qebmidi_pkg::MODE_SAMPLE, 3'd0, 1'b1, 1'b1, 8'd0);
    send_item(qebmidi_pkg::MODE_SAMPLE, 3'd0, 1'b1, 1'b0, 8'd0);
    send_item(qebmidi_pkg::MODE_SAMPLE, 3'd0, 1'b0, 1'b0, 8'd0);
    send_item(qebmidi_pkg::MODE_SAMPLE, 3'd0, 1'b0, 1'b1, 8'd0);
    // jump over a phase, then repeat the same phase: both hold
    send_item(qebmidi_pkg::MODE_SAMPLE, 3'd0, 1'b1, 1'b0, 8'd0);
    send_item(qebmidi_pkg::MODE_SAMPLE, 3'd0, 1'b1, 1'b0, 8'd0);
    // limit of zero
    send_item(qebmidi_pkg::MODE_SAMPLE, 3'd1, 1'b1, 1'b0, 8'd0);
    // load above the limit, then a holding sample clamps it
    send_item(qebmidi_pkg::MODE_LOAD, 3'd2, 1'b0, 1'b0, 8'd100);
    send_item(qebmidi_pkg::MODE_SAMPLE, 3'd2, 1'b0, 1'b0, 8'd0);
    // zero controller number, then a disabled encoder
    send_item(qebmidi_pkg::MODE_LOAD, 3'd3, 1'b0, 1'b0, 8'd50);
    send_item(qebmidi_pkg::MODE_SAMPLE, 3'd3, 1'b1, 1'b0, 8'd0);
    send_item(qebmidi_pkg::MODE_LOAD, 3'd7, 1'b1, 1'b1, 8'd9);
    // step up while sitting at the limit, then a step down from the limit
    send_item(qebmidi_pkg::MODE_LOAD, 3'd4, 1'b0, 1'b0, 8'd128);
    send_item(qebmidi_pkg::MODE_SAMPLE, 3'd4, 1'b1, 1'b0, 8'd0);
    send_item(qebmidi_pkg::MODE_LOAD, 3'd5, 1'b0, 1'b0, 8'd64);
    send_item(qebmidi_pkg::MODE_SAMPLE, 3'd5, 1'b1, 1'b0, 8'd0);
    send_item(qebmidi_pkg::MODE_LOAD, 3'd6, 1'b0, 1'b0, 8'd1);
    send_item(qebmidi_pkg::MODE_SAMPLE, 3'd6, 1'b0, 1'b1, 8'd0);
    for (int k = 0; k < 8; k++) stim_ab[k] = cc_model.last_ab[k];

    for (int ph = 1; ph <= RANDOM_PHASES; ph++) begin
      drain_bank();
      setup_phase(ph);
      run_phase(PHASE_ITEMS);
    end

    drain_bank();
    if (cc_model.errors == 0 && cc_model.pending_cc.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/qebmidi_pkg.sv
rtl/qebmidi_update.sv
rtl/quadrature_encoder_bank_to_midi_cc_unit.sv
dv/tb_quadrature_encoder_bank_to_midi_cc_unit.sv
